>>> src/button_debounce_press_classifier_core_defines.svh
// assertion macros for the button debounce press classifier
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_DEFINES_SVH

// checked on every rising edge outside reset
`define BDPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define BDPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bdpc_pkg.sv
// package with types and constants of the button debounce press classifier
package bdpc_pkg;

  // reset values of the configuration registers
  localparam logic [3:0]  DEBOUNCE_SAMPLES_RESET = 4'd5;
  localparam logic [15:0] HOLD_TICKS_RESET       = 16'd400;

  // default width of the tick stamp arithmetic
  localparam int TICK_BITS_DEFAULT = 16;

  // saturation value of the held tick sum
  localparam logic [15:0] SUM_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [0:0] CFG_DEBOUNCE_SAMPLES = 1'b0;
  localparam logic [0:0] CFG_HOLD_TICKS       = 1'b1;

  // press machine phases
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HELD     = 2'd2
  } phase_t;

  // one result item
  typedef struct packed {
    logic   short_press_taken;
    logic   long_press_taken;
    logic   level_pressed;
    phase_t press_phase;
  } result_t;

endpackage

>>> src/button_debounce_press_classifier_core.sv
// top level of the button debounce press classifier
// One item is accepted per clock cycle while in_ready is high, and its result is registered
// in the result register, or in the skid register while the output stalls. The debouncer,
// the press machine and the flag takes are all combinational logic between the accepted
// inputs and those registers. A skid register behind the result register holds one more
// result, so the input side can accept one more item after the output stalls; in_ready drops
// only while that skid register is full. No clearing pass follows reset: the block accepts
// items on the first cycle after reset is released.
module button_debounce_press_classifier_core #(
  parameter int TICK_BITS = bdpc_pkg::TICK_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        sample_en,
  input  logic        raw_level,
  input  logic        update_en,
  input  logic [15:0] now_ticks,
  input  logic        take_short,
  input  logic        take_long,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        short_press_taken,
  output logic        long_press_taken,
  output logic        level_pressed,
  output logic [1:0]  press_phase
);
  import bdpc_pkg::*;

  `include "button_debounce_press_classifier_core_defines.svh"

  // width of the held sum addition with its carry
  localparam int SumW = ((TICK_BITS > 16) ? TICK_BITS : 16) + 1;

  // configuration registers
  logic [3:0]  debounce_samples;
  logic [15:0] hold_ticks;

  // block state
  logic                 last_raw;
  logic [3:0]           stable_count;
  logic                 debounced_level;
  phase_t               phase;
  logic [TICK_BITS-1:0] last_stamp;
  logic [15:0]          held_sum;
  logic                 short_pending;
  logic                 long_pending;

  logic                 last_raw_next;
  logic [3:0]           stable_count_next;
  logic                 debounced_level_next;
  phase_t               phase_next;
  logic [TICK_BITS-1:0] last_stamp_next;
  logic [15:0]          held_sum_next;
  logic                 short_pending_next;
  logic                 long_pending_next;
  result_t              res_next;

  // output registers
  logic    skid_valid;
  result_t result;
  result_t skid;

  logic                 accept;
  logic                 pop;
  logic [TICK_BITS-1:0] now_stamp;
  logic [TICK_BITS-1:0] elapsed;
  logic [SumW-1:0]      sum_wide;
  logic [15:0]          sum_sat;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // elapsed ticks wrap at the stamp width, the sum saturates
  assign now_stamp = TICK_BITS'(now_ticks);
  assign elapsed   = now_stamp - last_stamp;
  assign sum_wide  = SumW'(held_sum) + SumW'(elapsed);
  assign sum_sat   = (sum_wide > SumW'(SUM_MAX)) ? SUM_MAX : sum_wide[15:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_samples <= DEBOUNCE_SAMPLES_RESET;
      hold_ticks       <= HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_SAMPLES: debounce_samples <= cfg_data[3:0];
        CFG_HOLD_TICKS:       hold_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // debounce, then press machine, then flag takes
  always_comb begin
    last_raw_next        = last_raw;
    stable_count_next    = stable_count;
    debounced_level_next = debounced_level;
    phase_next           = phase;
    last_stamp_next      = last_stamp;
    held_sum_next        = held_sum;
    short_pending_next   = short_pending;
    long_pending_next    = long_pending;

    // counting debouncer
    if (sample_en) begin
      if (raw_level == last_raw) begin
        if (stable_count < debounce_samples) begin
          stable_count_next = stable_count + 4'd1;
        end
      end else begin
        stable_count_next = 4'd1;
        last_raw_next     = raw_level;
      end
      if (stable_count_next >= debounce_samples) begin
        debounced_level_next = !last_raw_next;
      end
    end

    // released, pressed, held machine
    if (update_en) begin
      if (debounced_level_next) begin
        unique case (phase)
          PH_RELEASED: begin
            phase_next      = PH_PRESSED;
            last_stamp_next = now_stamp;
            held_sum_next   = 16'd1;
          end
          PH_PRESSED: begin
            if (held_sum < hold_ticks) begin
              held_sum_next   = sum_sat;
              last_stamp_next = now_stamp;
            end else begin
              long_pending_next = 1'b1;
              phase_next        = PH_HELD;
            end
          end
          PH_HELD: ;
          default: ;
        endcase
      end else begin
        if (phase == PH_PRESSED) begin
          short_pending_next = 1'b1;
        end
        phase_next    = PH_RELEASED;
        held_sum_next = 16'd0;
      end
    end

    // flag takes see the flags after the machine update
    res_next.short_press_taken = take_short && short_pending_next;
    res_next.long_press_taken  = take_long && long_pending_next;
    if (take_short) begin
      short_pending_next = 1'b0;
    end
    if (take_long) begin
      long_pending_next = 1'b0;
    end
    res_next.level_pressed = debounced_level_next;
    res_next.press_phase   = phase_next;
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw        <= 1'b1;
      stable_count    <= 4'd0;
      debounced_level <= 1'b0;
      phase           <= PH_RELEASED;
      last_stamp      <= '0;
      held_sum        <= 16'd0;
      short_pending   <= 1'b0;
      long_pending    <= 1'b0;
    end else if (accept) begin
      last_raw        <= last_raw_next;
      stable_count    <= stable_count_next;
      debounced_level <= debounced_level_next;
      phase           <= phase_next;
      last_stamp      <= last_stamp_next;
      held_sum        <= held_sum_next;
      short_pending   <= short_pending_next;
      long_pending    <= long_pending_next;
    end
  end

  // result register and skid register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid <= res_next;
      end else begin
        result <= res_next;
      end
    end
  end

  assign short_press_taken = result.short_press_taken;
  assign long_press_taken  = result.long_press_taken;
  assign level_pressed     = result.level_pressed;
  assign press_phase       = result.press_phase;

  // checks
  `BDPC_ASSERT(skid_implies_result, skid_valid |-> out_valid, "skid full with result empty")
  `BDPC_ASSERT(sum_zero_iff_released, (phase == PH_RELEASED) == (held_sum == 16'd0), "held sum out of step with phase")
  `BDPC_ASSERT(short_from_pressed, $rose(short_pending) |-> ($past(phase) == PH_PRESSED), "short press latched outside pressed")
  `BDPC_ASSERT_ALWAYS(reset_empties_output, rst |=> (!out_valid && !skid_valid), "output not empty after reset")

endmodule

>>> dv/button_debounce_press_classifier_core_test.sv
// self-checking testbench for the button debounce press classifier core
module button_debounce_press_classifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 105;

  // one input transfer
  typedef struct packed {
    logic        sample_en;
    logic        raw_level;
    logic        update_en;
    logic [15:0] now_ticks;
    logic        take_short;
    logic        take_long;
  } press_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_DEBOUNCE_SAMPLES;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        sample_en = 1'b0;
  logic        raw_level = 1'b1;
  logic        update_en = 1'b0;
  logic [15:0] now_ticks = '0;
  logic        take_short = 1'b0;
  logic        take_long = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        short_press_taken;
  logic        long_press_taken;
  logic        level_pressed;
  logic [1:0]  press_phase;

  button_debounce_press_classifier_core dut (.*);

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predicted button state and register copies
  logic [3:0]  need_samples = DEBOUNCE_SAMPLES_RESET;
  logic [15:0] long_limit = HOLD_TICKS_RESET;
  logic        seen_raw = 1'b1;
  logic [3:0]  equal_run = '0;
  logic        stable_pressed = 1'b0;
  phase_t      button_phase = PH_RELEASED;
  logic [15:0] press_stamp = '0;
  logic [15:0] pressed_ticks = '0;
  logic        short_latched = 1'b0;
  logic        long_latched = 1'b0;

  result_t expected_results[$];
  int mismatches = 0;
  int transfers = 0;
  int settings = 0;
  int shorts_taken = 0;
  int longs_taken = 0;
  int cycles = 0;

  // sender burst state
  int burst_left = 0;

  // debounce, then press machine, then flag takes
  function automatic result_t classify_press(input press_item_t it);
    result_t r;
    logic [15:0] elapsed;
    logic [16:0] total;
    if (it.sample_en) begin
      if (it.raw_level == seen_raw) begin
        if (equal_run < need_samples) equal_run = equal_run + 4'd1;
      end else begin
        equal_run = 4'd1;
        seen_raw = it.raw_level;
      end
      if (equal_run >= need_samples) stable_pressed = !seen_raw;
    end
    if (it.update_en) begin
      if (stable_pressed) begin
        case (button_phase)
          PH_RELEASED: begin
            button_phase = PH_PRESSED;
            press_stamp = it.now_ticks;
            pressed_ticks = 16'd1;
          end
          PH_PRESSED: begin
            if (pressed_ticks < long_limit) begin
              elapsed = it.now_ticks - press_stamp;
              total = {1'b0, pressed_ticks} + {1'b0, elapsed};
              pressed_ticks = total[16] ? SUM_MAX : total[15:0];
              press_stamp = it.now_ticks;
            end else begin
              long_latched = 1'b1;
              button_phase = PH_HELD;
            end
          end
          default: ;
        endcase
      end else begin
        if (button_phase == PH_PRESSED) short_latched = 1'b1;
        button_phase = PH_RELEASED;
        pressed_ticks = '0;
      end
    end
    r.short_press_taken = it.take_short && short_latched;
    if (r.short_press_taken) short_latched = 1'b0;
    r.long_press_taken = it.take_long && long_latched;
    if (r.long_press_taken) long_latched = 1'b0;
    r.level_pressed = stable_pressed;
    r.press_phase = button_phase;
    return r;
  endfunction

  function automatic press_item_t make_item(input logic se, input logic raw, input logic ue,
                                            input logic [15:0] now, input logic ts,
                                            input logic tl);
    press_item_t it;
    it.sample_en = se;
    it.raw_level = raw;
    it.update_en = ue;
    it.now_ticks = now;
    it.take_short = ts;
    it.take_long = tl;
    return it;
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic transfer_item(input press_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    sample_en <= it.sample_en;
    raw_level <= it.raw_level;
    update_en <= it.update_en;
    now_ticks <= it.now_ticks;
    take_short <= it.take_short;
    take_long <= it.take_long;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(classify_press(it));
    transfers++;
    @(negedge clk);
  endtask

  // drop valid and let every expected result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEBOUNCE_SAMPLES) need_samples = value[3:0];
    else long_limit = value;
  endtask

  task automatic apply_setting(input logic [3:0] samples, input logic [15:0] hold);
    write_register(CFG_DEBOUNCE_SAMPLES, {12'h000, samples});
    write_register(CFG_HOLD_TICKS, hold);
    settings++;
  endtask

  // reset register values: five equal samples accept a press
  task automatic test_reset_defaults();
    for (int i = 0; i < 5; i++) transfer_item(make_item(1, 0, 1, 16'(i * 10), 0, 0));
    transfer_item(make_item(1, 0, 1, 16'd450, 1, 1));
  endtask

  // zero sample count and zero hold limit, tick stamp wrapping
  task automatic test_zero_thresholds();
    apply_setting(4'd0, 16'd0);
    transfer_item(make_item(1, 1, 1, 16'd7, 0, 0));
    transfer_item(make_item(1, 0, 1, 16'hFFFF, 0, 0));
    transfer_item(make_item(0, 0, 1, 16'h0000, 0, 1));
    transfer_item(make_item(0, 1, 0, 16'h1234, 0, 1));
    transfer_item(make_item(1, 1, 1, 16'h0001, 1, 0));
  endtask

  // backwards stamp saturates the held sum, bounce while pressed, disabled machine
  task automatic test_saturation_and_bounce();
    apply_setting(4'd2, 16'hFFFF);
    transfer_item(make_item(1, 0, 1, 16'd100, 0, 0));
    transfer_item(make_item(1, 0, 1, 16'd100, 0, 0));
    transfer_item(make_item(0, 1, 1, 16'd99, 0, 0));
    transfer_item(make_item(1, 1, 0, 16'd3, 1, 1));
    transfer_item(make_item(1, 0, 1, 16'd5, 0, 1));
  endtask

  // release from pressed latches a short press; takes with nothing pending
  task automatic test_short_press_takes();
    apply_setting(4'd1, HOLD_TICKS_RESET);
    transfer_item(make_item(1, 1, 1, 16'd0, 0, 0));
    transfer_item(make_item(1, 0, 1, 16'd10, 0, 0));
    transfer_item(make_item(1, 1, 1, 16'd20, 1, 1));
    transfer_item(make_item(0, 0, 0, 16'd0, 1, 1));
  endtask

  // bouncy presses of random length under several register settings
  task automatic test_random_traffic();
    logic [3:0]  samples_set[RANDOM_PHASES] = '{4'd1, 4'd15, 4'd5, 4'd0, 4'd3, 4'd1};
    logic [15:0] hold_set[RANDOM_PHASES] = '{16'd1, 16'hFFFF, 16'd400, 16'd0, 16'd0, 16'd0};
    logic        intended;
    int          run_left;
    logic [15:0] tick_now;
    press_item_t it;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p >= 4) hold_set[p] = 16'($urandom_range(1, 3000));
      if (p == 5) samples_set[p] = 4'($urandom_range(1, 15));
      apply_setting(samples_set[p], hold_set[p]);
      intended = 1'b1;
      run_left = 0;
      tick_now = 16'($urandom);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (run_left == 0) begin
          intended = !intended;
          run_left = $urandom_range(1, 60);
        end
        run_left--;
        if ($urandom_range(0, 15) == 0) tick_now = tick_now + 16'($urandom);
        else tick_now = tick_now + 16'($urandom_range(0, 60));
        if ($urandom_range(0, 19) == 0) begin
          it = press_item_t'($urandom);
        end else begin
          it.sample_en = ($urandom_range(0, 9) != 0);
          it.raw_level = ($urandom_range(0, 15) == 0) ? !intended : intended;
          it.update_en = ($urandom_range(0, 7) != 0);
          it.now_ticks = tick_now;
          it.take_short = ($urandom_range(0, 3) == 0);
          it.take_long = ($urandom_range(0, 3) == 0);
        end
        transfer_item(it);
      end
    end
  endtask

  // receiver stalls, switching among four ready patterns
  int rx_tick = 0;
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case ((rx_tick / 97) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rx_tick % 5) != 0);
    endcase
  end

  task automatic check_field(input string name, input logic [1:0] exp_v, input logic [1:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got);
      mismatches++;
    end
  endtask

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("short_press_taken", exp_r.short_press_taken, short_press_taken);
        check_field("long_press_taken", exp_r.long_press_taken, long_press_taken);
        check_field("level_pressed", exp_r.level_pressed, level_pressed);
        check_field("press_phase", exp_r.press_phase, press_phase);
        if (exp_r.short_press_taken) shorts_taken++;
        if (exp_r.long_press_taken) longs_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_zero_thresholds();
    test_saturation_and_bounce();
    test_short_press_takes();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      mismatches++;
    end
    $display("sent %0d transfers under %0d register settings", transfers, settings);
    $display("short presses taken %0d, long presses taken %0d", shorts_taken, longs_taken);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
